/* rtl/scsr_pkg.sv */
package scsr_pkg;

  localparam int LISTS_MAX = 1024;
  localparam int ITEMS_MAX = 65536;

  localparam int LIST_AW  = $clog2(LISTS_MAX);      // list_count / fill_pointer address
  localparam int START_AW = $clog2(LISTS_MAX + 1);  // list_start address
  localparam int ITEM_AW  = $clog2(ITEMS_MAX);      // item store address
  localparam int CNT_W    = ITEM_AW + 1;            // counts and offsets up to ITEMS_MAX

  localparam int NUM_W = 11;  // num_lists register
  localparam int REQ_W = 2;
  localparam int CID_W = 16;
  localparam int IDX_W = 17;
  localparam int STS_W = 3;
  localparam int VAL_W = 17;

  localparam int S_TDATA_W = ((CID_W + IDX_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD,
    REQ_FINISH,
    REQ_READ_START,
    REQ_READ_ITEM
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK,
    STS_BAD_ID,
    STS_FULL,
    STS_BAD_INDEX,
    STS_NOT_BUILT
  } status_t;

  // where the result value of the pending stage comes from
  typedef enum logic [1:0] {
    SRC_IMM,
    SRC_START,
    SRC_ITEM
  } src_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FIN_INIT,
    S_PRE_RD,
    S_PRE_WR,
    S_SC_ID,
    S_SC_FP,
    S_SC_WR,
    S_DONE
  } state_t;

endpackage

/* rtl/stable_counting_sort_csr.sv */
// Load and read transactions: one per cycle unless m_* stalls; results pass st1 to m_*.
// Finish: a prefix pass over the count memory for the lists in use, then a scatter pass
//   over the loaded items that leaves out items whose list is not in use; the result follows.
// The first load after a finish is seen in S_IDLE and held off while S_CLEAR zeroes the counts.
// Reset (rst, synchronous, active high) starts the same sweep; s_tready stays low until
//   it ends, while configuration writes are taken as ever.
module stable_counting_sort_csr (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [scsr_pkg::NUM_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [scsr_pkg::S_TDATA_W-1:0] s_tdata,   // list id, index, zero fill
  input  logic [scsr_pkg::REQ_W-1:0]     s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [scsr_pkg::M_TDATA_W-1:0] m_tdata,   // value, zero fill
  output logic [scsr_pkg::STS_W-1:0]     m_tuser    // status
);
  import scsr_pkg::*;

  // memories
  logic [CNT_W-1:0]   lc_mem [LISTS_MAX];
  logic [CNT_W-1:0]   ls_mem [LISTS_MAX+1];
  logic [CNT_W-1:0]   fp_mem [LISTS_MAX];
  logic [LIST_AW-1:0] ic_mem [ITEMS_MAX];
  logic [ITEM_AW-1:0] so_mem [ITEMS_MAX];

  logic               lc_re, lc_we;
  logic [LIST_AW-1:0] lc_raddr, lc_waddr;
  logic [CNT_W-1:0]   lc_wdata, lc_rdata;
  logic                ls_re, ls_we;
  logic [START_AW-1:0] ls_raddr, ls_waddr;
  logic [CNT_W-1:0]    ls_wdata, ls_rdata;
  logic               fp_re, fp_we;
  logic [LIST_AW-1:0] fp_raddr, fp_waddr;
  logic [CNT_W-1:0]   fp_wdata, fp_rdata;
  logic               ic_re, ic_we;
  logic [ITEM_AW-1:0] ic_raddr, ic_waddr;
  logic [LIST_AW-1:0] ic_wdata, ic_rdata;
  logic               so_re, so_we;
  logic [ITEM_AW-1:0] so_raddr, so_waddr;
  logic [ITEM_AW-1:0] so_wdata, so_rdata;

  // control registers
  state_t             state, state_next;
  logic [NUM_W-1:0]   num_lists;
  logic [LIST_AW-1:0] clr_addr;
  logic [NUM_W-1:0]   pc;
  logic [CNT_W-1:0]   si, acc, item_total;
  logic               built;
  logic [NUM_W-1:0]   built_lists;
  logic [CNT_W-1:0]   built_total;

  // load count update track
  logic               ld1_valid;
  logic [LIST_AW-1:0] ld1_addr;
  logic               lw_valid;
  logic [LIST_AW-1:0] lw_addr;
  logic [CNT_W-1:0]   lw_data;
  logic [CNT_W-1:0]   cnt_old, cnt_new;

  // pending result stage
  logic               st1_valid;
  status_t            st1_status;
  logic [VAL_W-1:0]   st1_value;
  src_t               st1_src;

  // combinational
  logic [NUM_W-1:0]   n;
  req_t               req;
  logic [CID_W-1:0]   cid;
  logic [IDX_W-1:0]   idx;
  logic               out_free, st1_free, st1_adv, acc_in;
  status_t            req_status;
  logic [VAL_W-1:0]   req_value;
  src_t               req_src;
  logic               load_ok;
  logic               st1_load;
  status_t            st1_status_in;
  logic [VAL_W-1:0]   st1_value_in;
  src_t               st1_src_in;
  logic               finish_done, clear_done;
  logic [CNT_W-1:0]   si_inc;
  logic [NUM_W-1:0]   pc_inc;
  logic [VAL_W-1:0]   out_value;

  assign n = (num_lists > NUM_W'(LISTS_MAX)) ? NUM_W'(LISTS_MAX) : num_lists;
  assign req = req_t'(s_tuser);
  assign cid = s_tdata[CID_W-1:0];
  assign idx = s_tdata[CID_W+IDX_W-1:CID_W];

  assign out_free = !m_tvalid || m_tready;
  assign st1_free = !st1_valid || out_free;
  assign st1_adv  = st1_valid && out_free;
  assign acc_in   = s_tvalid && s_tready;

  assign si_inc = si + 1'b1;
  assign pc_inc = pc + 1'b1;

  // the count written on the previous edge is not yet in the read data
  assign cnt_old = (lw_valid && lw_addr == ld1_addr) ? lw_data : lc_rdata;
  assign cnt_new = cnt_old + 1'b1;

  // request decode
  always_comb begin
    req_status = STS_OK;
    req_value  = '0;
    req_src    = SRC_IMM;
    load_ok    = 1'b0;
    unique case (req)
      REQ_LOAD: begin
        if (cid >= {{(CID_W-NUM_W){1'b0}}, n}) begin
          req_status = STS_BAD_ID;
        end else if (item_total[ITEM_AW]) begin
          req_status = STS_FULL;
        end else begin
          load_ok   = 1'b1;
          req_value = VAL_W'(item_total);
        end
      end
      REQ_FINISH: begin
        req_src = SRC_IMM;
      end
      REQ_READ_START: begin
        if (!built) begin
          req_status = STS_NOT_BUILT;
        end else if (idx > {{(IDX_W-NUM_W){1'b0}}, built_lists}) begin
          req_status = STS_BAD_INDEX;
        end else begin
          req_src = SRC_START;
        end
      end
      REQ_READ_ITEM: begin
        if (!built) begin
          req_status = STS_NOT_BUILT;
        end else if (IDX_W'(idx) >= IDX_W'(built_total)) begin
          req_status = STS_BAD_INDEX;
        end else begin
          req_src = SRC_ITEM;
        end
      end
      default: req_status = STS_OK;
    endcase
  end

  // next state and memory controls
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    st1_load      = 1'b0;
    st1_status_in = req_status;
    st1_value_in  = req_value;
    st1_src_in    = req_src;
    finish_done   = 1'b0;
    clear_done    = 1'b0;

    lc_re    = 1'b0;
    lc_raddr = cid[LIST_AW-1:0];
    lc_we    = 1'b0;
    lc_waddr = ld1_addr;
    lc_wdata = cnt_new;
    ls_re    = 1'b0;
    ls_raddr = idx[START_AW-1:0];
    ls_we    = 1'b0;
    ls_waddr = '0;
    ls_wdata = '0;
    fp_re    = 1'b0;
    fp_raddr = ic_rdata;
    fp_we    = 1'b0;
    fp_waddr = pc[LIST_AW-1:0];
    fp_wdata = acc;
    ic_re    = 1'b0;
    ic_raddr = si[ITEM_AW-1:0];
    ic_we    = 1'b0;
    ic_waddr = item_total[ITEM_AW-1:0];
    ic_wdata = cid[LIST_AW-1:0];
    so_re    = 1'b0;
    so_raddr = idx[ITEM_AW-1:0];
    so_we    = 1'b0;
    so_waddr = fp_rdata[ITEM_AW-1:0];
    so_wdata = si[ITEM_AW-1:0];

    if (ld1_valid) begin
      lc_we = 1'b1;
    end

    unique case (state)
      S_CLEAR: begin
        lc_we    = 1'b1;
        lc_waddr = clr_addr;
        lc_wdata = '0;
        if (clr_addr == LIST_AW'(LISTS_MAX - 1)) begin
          clear_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        s_tready = st1_free && !(req == REQ_LOAD && built);
        if (s_tvalid && req == REQ_LOAD && built) begin
          state_next = S_CLEAR;
        end else if (acc_in) begin
          if (req == REQ_FINISH) begin
            state_next = S_FIN_INIT;
          end else begin
            st1_load = 1'b1;
          end
          lc_re = load_ok;
          ic_we = load_ok;
          ls_re = (req_src == SRC_START);
          so_re = (req_src == SRC_ITEM);
        end
      end
      S_FIN_INIT: begin
        ls_we = 1'b1;
        if (n == '0) begin
          state_next = (item_total == '0) ? S_DONE : S_SC_ID;
        end else begin
          state_next = S_PRE_RD;
        end
      end
      S_PRE_RD: begin
        lc_re      = 1'b1;
        lc_raddr   = pc[LIST_AW-1:0];
        state_next = S_PRE_WR;
      end
      S_PRE_WR: begin
        ls_we    = 1'b1;
        ls_waddr = START_AW'(pc_inc);
        ls_wdata = acc + lc_rdata;
        fp_we    = 1'b1;
        if (pc_inc == n) begin
          state_next = (item_total == '0) ? S_DONE : S_SC_ID;
        end else begin
          state_next = S_PRE_RD;
        end
      end
      S_SC_ID: begin
        ic_re      = 1'b1;
        state_next = S_SC_FP;
      end
      S_SC_FP: begin
        if ({1'b0, ic_rdata} < NUM_W'(n)) begin
          fp_re      = 1'b1;
          state_next = S_SC_WR;
        end else begin
          state_next = (si_inc == item_total) ? S_DONE : S_SC_ID;
        end
      end
      S_SC_WR: begin
        so_we    = !fp_rdata[ITEM_AW];
        fp_we    = 1'b1;
        fp_waddr = ic_rdata;
        fp_wdata = fp_rdata + 1'b1;
        state_next = (si_inc == item_total) ? S_DONE : S_SC_ID;
      end
      S_DONE: begin
        if (st1_free) begin
          st1_load      = 1'b1;
          st1_status_in = STS_OK;
          st1_value_in  = VAL_W'(acc);
          st1_src_in    = SRC_IMM;
          finish_done   = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memories: synchronous, registered read data held when not read
  always_ff @(posedge clk) begin
    if (lc_we) lc_mem[lc_waddr] <= lc_wdata;
    if (lc_re) lc_rdata <= lc_mem[lc_raddr];
  end

  always_ff @(posedge clk) begin
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    if (ls_re) ls_rdata <= ls_mem[ls_raddr];
  end

  always_ff @(posedge clk) begin
    if (fp_we) fp_mem[fp_waddr] <= fp_wdata;
    if (fp_re) fp_rdata <= fp_mem[fp_raddr];
  end

  always_ff @(posedge clk) begin
    if (ic_we) ic_mem[ic_waddr] <= ic_wdata;
    if (ic_re) ic_rdata <= ic_mem[ic_raddr];
  end

  always_ff @(posedge clk) begin
    if (so_we) so_mem[so_waddr] <= so_wdata;
    if (so_re) so_rdata <= so_mem[so_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_lists   <= NUM_W'(LISTS_MAX);
      clr_addr    <= '0;
      item_total  <= '0;
      built       <= 1'b0;
      built_lists <= '0;
      built_total <= '0;
      ld1_valid   <= 1'b0;
      lw_valid    <= 1'b0;
      st1_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) num_lists <= cfg_data;

      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (clear_done) begin
        item_total <= '0;
        built      <= 1'b0;
      end else if (state == S_IDLE && acc_in && load_ok) begin
        item_total <= item_total + 1'b1;
      end

      if (finish_done) begin
        built       <= 1'b1;
        built_lists <= n;
        built_total <= acc;
      end

      ld1_valid <= (state == S_IDLE) && acc_in && load_ok;
      lw_valid  <= ld1_valid;

      if (st1_load) begin
        st1_valid <= 1'b1;
      end else if (st1_adv) begin
        st1_valid <= 1'b0;
      end

      if (st1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and pass counters
  always_ff @(posedge clk) begin
    ld1_addr <= cid[LIST_AW-1:0];
    lw_addr  <= ld1_addr;
    lw_data  <= cnt_new;

    unique case (state)
      S_FIN_INIT: begin
        acc <= '0;
        pc  <= '0;
        si  <= '0;
      end
      S_PRE_WR: begin
        acc <= acc + lc_rdata;
        pc  <= pc_inc;
      end
      S_SC_FP: begin
        if (!({1'b0, ic_rdata} < NUM_W'(n))) si <= si_inc;
      end
      S_SC_WR: si <= si_inc;
      default: begin
        si <= si;
      end
    endcase

    if (st1_load) begin
      st1_status <= st1_status_in;
      st1_value  <= st1_value_in;
      st1_src    <= st1_src_in;
    end

    if (st1_adv) begin
      m_tuser <= st1_status;
      m_tdata <= {{(M_TDATA_W-VAL_W){1'b0}}, out_value};
    end
  end

  always_comb begin
    case (st1_src)
      SRC_START: out_value = VAL_W'(ls_rdata);
      SRC_ITEM:  out_value = VAL_W'(so_rdata);
      default:   out_value = st1_value;
    endcase
  end

`ifndef SYNTH
  // a count update never overlaps the clearing sweep
  a_no_update_in_clear: assert property (@(posedge clk) disable iff (rst)
    ld1_valid |-> state != S_CLEAR)
    else $error("count update during clearing sweep");

  // a finish never places more items than were loaded
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    built |-> built_total <= item_total)
    else $error("finish total exceeds loaded items");

  // the finish result marks the lists as built
  a_done_builds: assert property (@(posedge clk) disable iff (rst)
    finish_done |=> built && st1_valid)
    else $error("finish completed without built flag");

  // a stalled pending result is not overwritten
  a_st1_hold: assert property (@(posedge clk) disable iff (rst)
    (st1_valid && !out_free) |=> st1_valid && $stable(st1_value) && $stable(st1_src))
    else $error("pending result overwritten while stalled");
`endif

endmodule
